[rtl/mi3_pkg.sv]
// Shared types and constants for the 3x3 matrix inverse unit.
// No dependencies.
`default_nettype none
package mi3_pkg;
    localparam int N_ELEM  = 9;
    localparam int ELEM_W  = 32;
    localparam int COF_W   = 64;
    localparam int DET_W   = 98;
    localparam int QUO_W   = 35;
    localparam int THR_W   = 40;
    localparam int DATA_W  = N_ELEM * ELEM_W;
    localparam int REG_DET_THRESHOLD = 0;
    localparam logic [THR_W-1:0] THR_RESET = 40'd281;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;
endpackage
`default_nettype wire

[rtl/matrix_inverse_3x3_unit.sv]
// Top level of the 3x3 matrix inverse unit (adjugate method, Q16.16).
// Depends on mi3_pkg.
//
// One 3x3 matrix enters per transaction and one result leaves per transaction,
// one per cycle sustained while the output is not stalled. Seven stages
// form the element products, the signed cofactors and the determinant (split
// 32x32 partial products), then 35 restoring-division stages produce each
// inverse element as cofactor*2^(2F)/det rounded half away from zero, one
// quotient bit per stage for all nine elements in parallel, and a last stage
// rounds, saturates and applies the sign. A determinant whose magnitude in
// Q48 units is below det_threshold (or zero) echoes the input and sets the
// singular flag in m_tuser. The whole pipeline advances when the output
// register is empty or being taken, so a stall at the output holds every
// stage and nothing is lost or repeated. det_threshold sits at byte 0 of the
// configuration port; write it only while the unit is idle.
`default_nettype none
module matrix_inverse_3x3_unit
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    output logic                   pready,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ... in_r2c2, 32 bits each
    input  wire logic [DATA_W-1:0] s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // out_r0c0, out_r0c1, out_r0c2, out_r1c0, ... out_r2c2, 32 bits each
    output logic [DATA_W-1:0]      m_tdata,
    // singular
    output logic [0:0]             m_tuser
);
    localparam int NUM_W = COF_W + 2 * FRAC_BITS + 1;
    localparam int CW    = (NUM_W > DET_W + QUO_W - 1) ? NUM_W : DET_W + QUO_W - 1;
    localparam int NSTG  = QUO_W;

    logic [THR_W-1:0] thr_reg;
    logic             en;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == 4'(8 * REG_DET_THRESHOLD)) ? 64'(thr_reg) : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr == 4'(8 * REG_DET_THRESHOLD))
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // advance everything when the output register is free or being drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // front stages
    logic  va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg;
    elem_t a_reg [N_ELEM];
    elem_t b_a_reg [N_ELEM];
    cof_t  p_reg [2*N_ELEM];
    elem_t c_a_reg [N_ELEM];
    cof_t  cof_reg [N_ELEM];
    elem_t d_a_reg [N_ELEM];
    cof_t  d_cof_reg [N_ELEM];
    logic signed [64:0] plo_reg [3];
    logic signed [63:0] phi_reg [3];
    elem_t e_a_reg [N_ELEM];
    cof_t  e_cof_reg [N_ELEM];
    det_t  term_reg [3];
    elem_t f_a_reg [N_ELEM];
    cof_t  f_cof_reg [N_ELEM];
    det_t  det_reg;

    cof_t  p_next [2*N_ELEM];
    cof_t  cof_next [N_ELEM];
    det_t  term_next [3];

    always_comb
    begin
        int r0, r1, c0, c1;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r0 = (i == 0) ? 1 : 0;
                r1 = (i == 2) ? 1 : 2;
                c0 = (j == 0) ? 1 : 0;
                c1 = (j == 2) ? 1 : 2;
                p_next[2*(3*i+j)]   = a_reg[3*r0+c0] * a_reg[3*r1+c1];
                p_next[2*(3*i+j)+1] = a_reg[3*r1+c0] * a_reg[3*r0+c1];
                cof_next[3*i+j] = ((i + j) % 2 == 1) ?
                    p_reg[2*(3*i+j)+1] - p_reg[2*(3*i+j)] :
                    p_reg[2*(3*i+j)] - p_reg[2*(3*i+j)+1];
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            term_next[j] = ({{2{phi_reg[j][63]}}, phi_reg[j], 32'd0})
                         + DET_W'(plo_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                a_reg[k]     <= s_tdata[ELEM_W*k +: ELEM_W];
                b_a_reg[k]   <= a_reg[k];
                c_a_reg[k]   <= b_a_reg[k];
                cof_reg[k]   <= cof_next[k];
                d_a_reg[k]   <= c_a_reg[k];
                d_cof_reg[k] <= cof_reg[k];
                e_a_reg[k]   <= d_a_reg[k];
                e_cof_reg[k] <= d_cof_reg[k];
                f_a_reg[k]   <= e_a_reg[k];
                f_cof_reg[k] <= e_cof_reg[k];
            end
            for (int k = 0; k < 2*N_ELEM; k++)
            begin
                p_reg[k] <= p_next[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                // split the 32x64 expansion into two products by the 32-bit cofactor halves
                plo_reg[j]  <= c_a_reg[j] * $signed({1'b0, cof_reg[j][31:0]});
                phi_reg[j]  <= c_a_reg[j] * $signed(cof_reg[j][63:32]);
                term_reg[j] <= term_next[j];
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        end
    end

    // division pipeline, index 0 holds the prepared operands
    logic             vld_reg  [NSTG+1];
    logic             sing_reg [NSTG+1];
    logic [DET_W-1:0] den_reg  [NSTG+1];
    elem_t            el_reg   [NSTG+1][N_ELEM];
    logic [CW-1:0]    rem_reg  [NSTG+1][N_ELEM];
    logic [QUO_W-1:0] quo_reg  [NSTG+1][N_ELEM];
    logic             neg_reg  [NSTG+1][N_ELEM];

    logic             dneg;
    logic [DET_W-1:0] dmag;
    logic             sing_next;

    always_comb
    begin
        dneg      = det_reg[DET_W-1];
        dmag      = dneg ? DET_W'(-det_reg) : DET_W'(det_reg);
        sing_next = (dmag < DET_W'(thr_reg)) || (dmag == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cof_t c;
        if (en)
        begin
            sing_reg[0] <= sing_next;
            den_reg[0]  <= dmag;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    // inverse element (i,j) takes the cofactor at (j,i)
                    c = f_cof_reg[3*j+i];
                    el_reg[0][3*i+j]  <= f_a_reg[3*i+j];
                    neg_reg[0][3*i+j] <= c[COF_W-1] ^ dneg;
                    rem_reg[0][3*i+j] <= CW'(c[COF_W-1] ? COF_W'(-c) : COF_W'(c))
                                         << (2 * FRAC_BITS + 1);
                    quo_reg[0][3*i+j] <= '0;
                end
            end
        end
    end

    for (genvar s = 0; s < NSTG; s++)
    begin : g_div
        localparam int K = NSTG - 1 - s;
        logic [CW:0] diff [N_ELEM];

        always_comb
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                diff[k] = {1'b0, rem_reg[s][k]} - ((CW+1)'(den_reg[s]) << K);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sing_reg[s+1] <= sing_reg[s];
                den_reg[s+1]  <= den_reg[s];
                for (int k = 0; k < N_ELEM; k++)
                begin
                    el_reg[s+1][k]  <= el_reg[s][k];
                    neg_reg[s+1][k] <= neg_reg[s][k];
                    if (!diff[k][CW])
                    begin
                        rem_reg[s+1][k] <= diff[k][CW-1:0];
                        quo_reg[s+1][k] <= quo_reg[s][k] | (QUO_W'(1) << K);
                    end
                    else
                    begin
                        rem_reg[s+1][k] <= rem_reg[s][k];
                        quo_reg[s+1][k] <= quo_reg[s][k];
                    end
                end
            end
        end
    end

    // round half away, saturate, apply sign
    logic [DATA_W-1:0] res_next;

    always_comb
    begin
        logic [QUO_W-2:0] q1;
        logic [QUO_W-2:0] lim;
        logic [ELEM_W-1:0] m;
        for (int k = 0; k < N_ELEM; k++)
        begin
            q1  = (QUO_W-1)'(({1'b0, quo_reg[NSTG][k][QUO_W-2:0]} + 1'b1) >> 1);
            lim = neg_reg[NSTG][k] ? (QUO_W-1)'(33'h080000000) : (QUO_W-1)'(33'h07FFFFFFF);
            m   = (quo_reg[NSTG][k][QUO_W-1] || q1 > lim) ? lim[ELEM_W-1:0]
                                                          : q1[ELEM_W-1:0];
            if (sing_reg[NSTG])
            begin
                res_next[ELEM_W*k +: ELEM_W] = el_reg[NSTG][k];
            end
            else
            begin
                res_next[ELEM_W*k +: ELEM_W] = neg_reg[NSTG][k] ? -m : m;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid <= vld_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata    <= res_next;
            m_tuser[0] <= sing_reg[NSTG];
        end
    end

    // checks
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> va_reg)
        else $error("accepted transaction did not enter the pipeline");

    a_zero_det_singular: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && den_reg[0] == '0) |-> sing_reg[0])
        else $error("zero determinant not flagged singular");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(vld_reg[NSTG]) && $stable(vf_reg)))
        else $error("pipeline moved during a stall");
endmodule
`default_nettype wire

[verif/matrix_inverse_3x3_unit_tb.sv]
// Self-checking testbench for matrix_inverse_3x3_unit: random and directed 3x3 matrices,
// predicted inverses compared against the streamed results. Depends on mi3_pkg and the RTL.
module matrix_inverse_3x3_unit_tb
    import mi3_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int LATENCY = 43;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [DATA_W-1:0] elems;
        logic              singular;
    } inverse_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic [0:0]        m_tuser;

    matrix_inverse_3x3_unit #(.FRAC_BITS(FRAC)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Matrices waiting to be driven, and inverses waiting to come out.
    logic [DATA_W-1:0] matrix_queue[$];
    inverse_t          inverse_queue[$];
    logic [39:0]       threshold;
    int                send_idle_pct;
    int                recv_stall_pct;
    bit                failed;
    int                idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Predict the inverse of one matrix: exact cofactors, exact determinant,
    // rounded quotient with ties away from zero, saturated to 32 bits.
    function automatic inverse_t predict_inverse(logic [DATA_W-1:0] m);
        logic signed [63:0]  a[3][3];
        logic signed [63:0]  cof[3][3];
        logic signed [127:0] det;
        logic [127:0]        dmag;
        logic [127:0]        num;
        logic [127:0]        quot;
        logic [127:0]        rem;
        logic [127:0]        limit;
        logic                neg;
        logic                sing;
        inverse_t            res;
        int                  r0, r1, c0, c1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = 64'(signed'(m[(i*3+j)*ELEM_W +: ELEM_W]));
        for (int i = 0; i < 3; i++)
        begin
            r0 = (i == 0) ? 1 : 0;
            r1 = (i == 2) ? 1 : 2;
            for (int j = 0; j < 3; j++)
            begin
                c0 = (j == 0) ? 1 : 0;
                c1 = (j == 2) ? 1 : 2;
                cof[i][j] = a[r0][c0] * a[r1][c1] - a[r1][c0] * a[r0][c1];
                if ((i + j) % 2 == 1)
                    cof[i][j] = -cof[i][j];
            end
        end
        det = 128'(a[0][0]) * 128'(cof[0][0]) + 128'(a[0][1]) * 128'(cof[0][1])
            + 128'(a[0][2]) * 128'(cof[0][2]);
        dmag = det[127] ? -det : det;
        sing = (dmag == 0) || (dmag < {88'd0, threshold});
        res.singular = sing;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                if (sing)
                begin
                    res.elems[(i*3+j)*ELEM_W +: ELEM_W] = m[(i*3+j)*ELEM_W +: ELEM_W];
                end
                else
                begin
                    neg = cof[j][i][63] != det[127];
                    num = (cof[j][i][63] ? 128'(-cof[j][i]) : 128'(cof[j][i])) << (2*FRAC);
                    quot = num / dmag;
                    rem = num % dmag;
                    if ((rem << 1) >= dmag)
                        quot = quot + 1;
                    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                    if (quot > limit)
                        quot = limit;
                    quot = neg ? -quot : quot;
                    res.elems[(i*3+j)*ELEM_W +: ELEM_W] = quot[31:0];
                end
            end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pack_matrix(logic [31:0] e[9]);
        logic [DATA_W-1:0] m;
        for (int k = 0; k < 9; k++)
            m[k*ELEM_W +: ELEM_W] = e[k];
        return m;
    endfunction

    function automatic logic [31:0] random_elem();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC;
            3:       return 32'($signed($urandom_range(0, 512)) - 256);
            default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    // Mostly well-conditioned matrices; some rank-deficient ones and near-zero ones.
    function automatic logic [DATA_W-1:0] random_matrix();
        logic [31:0] e[9];
        for (int k = 0; k < 9; k++)
            e[k] = random_elem();
        case ($urandom_range(0, 9))
            0: for (int c = 0; c < 3; c++) e[6+c] = e[c];
            1: for (int c = 0; c < 3; c++) e[3+c] = 32'($signed(e[c]) >>> 1);
            2: for (int k = 0; k < 9; k++) e[k] = 32'($signed($urandom_range(0, 6)) - 3);
            default: ;
        endcase
        return pack_matrix(e);
    endfunction

    task automatic apb_write(logic [3:0] addr, logic [63:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        threshold = data[39:0];
    endtask

    // Hold until every queued matrix is sent and every result taken, then let the
    // pipeline drain before touching the register.
    task automatic wait_idle();
        while (matrix_queue.size() != 0 || inverse_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic add_random(int count);
        for (int k = 0; k < count; k++)
            matrix_queue.push_back(random_matrix());
    endtask

    // Driver: advance the next matrix when the sender is not idling.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                inverse_queue.push_back(predict_inverse(s_tdata));
            if (matrix_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= matrix_queue.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (inverse_queue.size() == 0)
                begin
                    $error("unexpected result transaction");
                    failed = 1'b1;
                end
                else
                begin
                    inverse_t exp_inv;
                    exp_inv = inverse_queue.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (m_tdata[k*ELEM_W +: ELEM_W] !== exp_inv.elems[k*ELEM_W +: ELEM_W])
                        begin
                            $error("out_r%0dc%0d: expected %h, got %h", k / 3, k % 3,
                                   exp_inv.elems[k*ELEM_W +: ELEM_W],
                                   m_tdata[k*ELEM_W +: ELEM_W]);
                            failed = 1'b1;
                        end
                    if (m_tuser[0] !== exp_inv.singular)
                    begin
                        $error("singular: expected %b, got %b", exp_inv.singular, m_tuser[0]);
                        failed = 1'b1;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] e[9];
        failed         = 1'b0;
        idle_cycles    = 0;
        threshold      = THR_RESET;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: identity, zero, field extremes, large inverses, small determinants.
        for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 32'h0001_0000 : 32'h0;
        matrix_queue.push_back(pack_matrix(e));
        for (int k = 0; k < 9; k++) e[k] = 32'h0;
        matrix_queue.push_back(pack_matrix(e));
        for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 32'h7FFF_FFFF : 32'h0;
        matrix_queue.push_back(pack_matrix(e));
        for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 32'h8000_0000 : 32'h0;
        matrix_queue.push_back(pack_matrix(e));
        for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 32'h0000_0001 : 32'h0;
        matrix_queue.push_back(pack_matrix(e));   // tiny det, singular at reset threshold
        for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 32'h0000_0100 : 32'h0;
        matrix_queue.push_back(pack_matrix(e));   // inverse diagonal of 256.0
        for (int k = 0; k < 9; k++) e[k] = (k == 0) ? 32'hFFFF_FF00 : ((k % 4 == 0) ? 32'h100 : 0);
        matrix_queue.push_back(pack_matrix(e));   // inverse diagonal of -256.0, 256.0, 256.0
        for (int k = 0; k < 9; k++) e[k] = (k == 4) ? 32'h0000_0007 : ((k % 4 == 0) ? 32'h40 : 0);
        matrix_queue.push_back(pack_matrix(e));   // det of 28672, above the reset threshold of 281
        for (int k = 0; k < 9; k++) e[k] = 32'hFFFF_FFFF;
        matrix_queue.push_back(pack_matrix(e));
        for (int k = 0; k < 9; k++) e[k] = 32'h8000_0000 >> k;
        matrix_queue.push_back(pack_matrix(e));
        for (int k = 0; k < 9; k++) e[k] = 32'h7FFF_FFFF ^ (32'h1 << (k * 3));
        matrix_queue.push_back(pack_matrix(e));
        add_random(12);
        wait_idle();

        // Zero threshold: only an exact zero determinant is singular.
        apb_write(4'(REG_DET_THRESHOLD * 8), 64'd0);
        for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? 32'h0000_0001 : 32'h0;
        matrix_queue.push_back(pack_matrix(e));
        for (int k = 0; k < 9; k++) e[k] = 32'h0;
        matrix_queue.push_back(pack_matrix(e));
        add_random(200);
        wait_idle();

        // Sender idling.
        send_idle_pct = 73;
        apb_write(4'(REG_DET_THRESHOLD * 8), 64'hFF_FFFF_FFFF);
        add_random(200);
        wait_idle();

        // Receiver stalling; pause the sender until the pipeline is empty midway.
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        apb_write(4'(REG_DET_THRESHOLD * 8), 64'd1 << 32);
        add_random(150);
        wait_idle();
        add_random(100);
        wait_idle();

        // Both sides idling, threshold back at reset value.
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        apb_write(4'(REG_DET_THRESHOLD * 8), 64'(THR_RESET));
        add_random(220);
        wait_idle();

        // Back to full rate.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_random(200);
        wait_idle();

        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

[files.f]
rtl/mi3_pkg.sv
rtl/matrix_inverse_3x3_unit.sv
verif/matrix_inverse_3x3_unit_tb.sv
